@@ sv/ptst_pkg.sv @@
// Package for the periodic task slot table: transfer structs, operation and
// status codes, and the layout of one stored slot entry. No dependencies.
package ptst_pkg;

  localparam int unsigned SLOTS_DEF = 8;

  localparam logic [2:0] OP_CLEAR    = 3'd0;
  localparam logic [2:0] OP_CREATE   = 3'd1;
  localparam logic [2:0] OP_RUN      = 3'd2;
  localparam logic [2:0] OP_SHUTDOWN = 3'd3;
  localparam logic [2:0] OP_SNAPSHOT = 3'd4;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_REFUSED   = 2'd1;
  localparam logic [1:0] ST_NONE_DUE  = 2'd2;
  localparam logic [1:0] ST_BAD_INDEX = 2'd3;

  typedef struct packed {
    logic [2:0]  operation;
    logic [63:0] now;
    logic [31:0] period;
    logic        first_due_now;
    logic        has_entry;
    logic [3:0]  slot_index;
  } ptst_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  slot;
    logic        last;
    logic [3:0]  active_count;
    logic        slot_used;
    logic        slot_has_entry;
    logic [31:0] slot_period;
    logic [63:0] slot_next_due;
    logic [63:0] slot_last_run;
    logic [31:0] slot_run_count;
  } ptst_out_t;

  // One slot as it sits in the table memory. The used flag lives in flops.
  typedef struct packed {
    logic        has_entry;
    logic [31:0] period;
    logic [63:0] next_due;
    logic [63:0] last_run;
    logic [31:0] fire_count;
  } ptst_entry_t;

  localparam int unsigned ENTRY_W = $bits(ptst_entry_t);

endpackage

@@ sv/ptst_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No package dependencies.
module ptst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ sv/ptst_alu.sv @@
// Shared 64-bit adder of the slot table: due-time compare and update, first due
// time at create, and run-count increment. No package dependencies.
module ptst_alu (
  input  logic [63:0] a_i,
  input  logic [63:0] b_i,
  input  logic        cin_i,
  output logic [63:0] sum_o,
  output logic        cout_o
);

  // With b = ~x and carry in set, the carry out means a >= x.
  assign {cout_o, sum_o} = {1'b0, a_i} + {1'b0, b_i} + {64'd0, cin_i};

endmodule

@@ sv/periodic_task_slot_table.sv @@
// Top level of the periodic task slot table: sequencer, used flags and
// result register. Depends on ptst_pkg, ptst_ram and ptst_alu.
//
//   channel | handshake               | payload              | transfer at edge with
//   --------+-------------------------+----------------------+----------------------
//   command | start in, busy out      | item_i   ptst_in_t   | start high, busy low
//   result  | result_valid_o out      | result_o ptst_out_t  | result_valid_o high
//
// Clear, shutdown, refusals, bad indexes and unknown operations answer with busy
// low; snapshot reads the chosen slot; create scans the used slots below the
// lowest free one, then writes it. Run-ready makes one table read per slot and
// two shared-adder steps per firing. Reset clears the used flags, count and stop
// flag; results cannot be stalled, busy is the only stall.
module periodic_task_slot_table import ptst_pkg::*; #(
  parameter int unsigned SLOTS = SLOTS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start,
  output logic      busy,
  input  ptst_in_t  item_i,
  output logic      result_valid_o,
  output ptst_out_t result_o
);

  localparam int unsigned IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned CNTW = $clog2(SLOTS + 1);

  typedef enum logic [6:0] {
    S_IDLE     = 7'b0000001,
    S_CRT_SCAN = 7'b0000010,
    S_CRT_WR   = 7'b0000100,
    S_RUN_CMP  = 7'b0001000,
    S_RUN_ADD  = 7'b0010000,
    S_RUN_INC  = 7'b0100000,
    S_RUN_END  = 7'b1000000
  } state_e;

  // Snapshot reuses the compare state's read slot through its own flag.
  state_e            state_q, state_d;
  logic              snap_q, snap_d;
  ptst_in_t          item_q, item_d;
  logic [IDXW-1:0]   idx_q, idx_d;
  logic [SLOTS-1:0]  used_q, used_d;
  logic [CNTW-1:0]   count_q, count_d;
  logic              stopped_q, stopped_d;
  logic              pend_q, pend_d;
  ptst_out_t         pend_res_q, pend_res_d;
  ptst_entry_t       ent_q, ent_d;
  logic              res_valid_q, res_valid_d;
  ptst_out_t         res_q, res_d;

  ptst_entry_t       rd_entry;
  logic [ENTRY_W-1:0] rd_data;
  logic              ram_we;
  ptst_entry_t       ram_wdata;

  logic [63:0]       alu_a, alu_b, alu_sum;
  logic              alu_cin, alu_cout;

  logic              idx_last;
  logic              eligible;

  ptst_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (idx_q),
    .wdata_i (ram_wdata),
    .raddr_i (idx_d),
    .rdata_o (rd_data)
  );

  assign rd_entry = ptst_entry_t'(rd_data);

  ptst_alu u_alu (
    .a_i    (alu_a),
    .b_i    (alu_b),
    .cin_i  (alu_cin),
    .sum_o  (alu_sum),
    .cout_o (alu_cout)
  );

  assign idx_last = (idx_q == IDXW'(SLOTS - 1));
  assign eligible = used_q[idx_q] && rd_entry.has_entry;

  // Operand selection for the shared adder.
  always_comb begin
    alu_a   = '0;
    alu_b   = '0;
    alu_cin = 1'b0;
    unique case (state_q)
      S_RUN_CMP: begin
        alu_a   = item_q.now;
        alu_b   = ~rd_entry.next_due;
        alu_cin = 1'b1;
      end
      S_RUN_ADD: begin
        alu_a = item_q.now;
        alu_b = {32'd0, ent_q.period};
      end
      S_RUN_INC: begin
        alu_a   = {32'd0, ent_q.fire_count};
        alu_cin = 1'b1;
      end
      S_CRT_WR: begin
        alu_a = item_q.now;
        alu_b = {32'd0, item_q.period};
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_d     = state_q;
    snap_d      = snap_q;
    item_d      = item_q;
    idx_d       = idx_q;
    used_d      = used_q;
    count_d     = count_q;
    stopped_d   = stopped_q;
    pend_d      = pend_q;
    pend_res_d  = pend_res_q;
    ent_d       = ent_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    ram_we      = 1'b0;
    ram_wdata   = ent_q;

    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          item_d = item_i;
          if (item_i.period == 32'd0) begin
            item_d.period = 32'd1;
          end
          res_d              = '0;
          res_d.last         = 1'b1;
          res_d.active_count = 4'(count_q);
          unique case (item_i.operation)
            OP_CLEAR, OP_SHUTDOWN: begin
              used_d      = '0;
              count_d     = '0;
              stopped_d   = (item_i.operation == OP_SHUTDOWN);
              res_d.status       = ST_OK;
              res_d.active_count = '0;
              res_valid_d = 1'b1;
            end
            OP_CREATE: begin
              if (stopped_q || (count_q == CNTW'(SLOTS))) begin
                res_d.status = ST_REFUSED;
                res_valid_d  = 1'b1;
              end else begin
                idx_d   = '0;
                state_d = S_CRT_SCAN;
              end
            end
            OP_RUN: begin
              if (stopped_q) begin
                res_d.status = ST_REFUSED;
                res_valid_d  = 1'b1;
              end else begin
                idx_d   = '0;
                pend_d  = 1'b0;
                snap_d  = 1'b0;
                state_d = S_RUN_CMP;
              end
            end
            OP_SNAPSHOT: begin
              if ({28'd0, item_i.slot_index} >= 32'(SLOTS)) begin
                res_d.status = ST_BAD_INDEX;
                res_valid_d  = 1'b1;
              end else begin
                idx_d   = IDXW'(item_i.slot_index);
                snap_d  = 1'b1;
                state_d = S_RUN_CMP;
              end
            end
            default: begin
              res_d.status = ST_REFUSED;
              res_valid_d  = 1'b1;
            end
          endcase
        end
      end

      S_CRT_SCAN: begin
        // A free slot is known to exist, so the search always ends.
        if (used_q[idx_q]) begin
          idx_d = idx_q + IDXW'(1);
        end else begin
          state_d = S_CRT_WR;
        end
      end

      S_CRT_WR: begin
        ram_we               = 1'b1;
        ram_wdata.has_entry  = item_q.has_entry;
        ram_wdata.period     = item_q.period;
        ram_wdata.next_due   = item_q.first_due_now ? item_q.now : alu_sum;
        ram_wdata.last_run   = '0;
        ram_wdata.fire_count = '0;
        used_d[idx_q]        = 1'b1;
        count_d              = count_q + CNTW'(1);
        res_d                = '0;
        res_d.status         = ST_OK;
        res_d.slot           = 3'(idx_q);
        res_d.last           = 1'b1;
        res_d.active_count   = 4'(count_d);
        res_valid_d          = 1'b1;
        state_d              = S_IDLE;
      end

      S_RUN_CMP: begin
        if (snap_q) begin
          // Table data of an unused slot is stale or never written: show zeros.
          res_d              = '0;
          res_d.status       = ST_OK;
          res_d.slot         = 3'(idx_q);
          res_d.last         = 1'b1;
          res_d.active_count = 4'(count_q);
          if (used_q[idx_q]) begin
            res_d.slot_used      = 1'b1;
            res_d.slot_has_entry = rd_entry.has_entry;
            res_d.slot_period    = rd_entry.period;
            res_d.slot_next_due  = rd_entry.next_due;
            res_d.slot_last_run  = rd_entry.last_run;
            res_d.slot_run_count = rd_entry.fire_count;
          end
          res_valid_d = 1'b1;
          snap_d      = 1'b0;
          state_d     = S_IDLE;
        end else if (eligible && alu_cout) begin
          ent_d   = rd_entry;
          state_d = S_RUN_ADD;
        end else if (idx_last) begin
          state_d = S_RUN_END;
        end else begin
          idx_d = idx_q + IDXW'(1);
        end
      end

      S_RUN_ADD: begin
        ent_d.next_due = alu_sum;
        ent_d.last_run = item_q.now;
        state_d        = S_RUN_INC;
      end

      S_RUN_INC: begin
        ram_we               = 1'b1;
        ram_wdata.fire_count = alu_sum[31:0];
        // The previous firing is now known not to be the final one.
        if (pend_q) begin
          res_d       = pend_res_q;
          res_d.last  = 1'b0;
          res_valid_d = 1'b1;
        end
        pend_d                    = 1'b1;
        pend_res_d                = '0;
        pend_res_d.status         = ST_OK;
        pend_res_d.slot           = 3'(idx_q);
        pend_res_d.last           = 1'b1;
        pend_res_d.active_count   = 4'(count_q);
        pend_res_d.slot_used      = 1'b1;
        pend_res_d.slot_has_entry = 1'b1;
        pend_res_d.slot_period    = ent_q.period;
        pend_res_d.slot_next_due  = ent_q.next_due;
        pend_res_d.slot_last_run  = ent_q.last_run;
        pend_res_d.slot_run_count = alu_sum[31:0];
        if (idx_last) begin
          state_d = S_RUN_END;
        end else begin
          idx_d   = idx_q + IDXW'(1);
          state_d = S_RUN_CMP;
        end
      end

      S_RUN_END: begin
        if (pend_q) begin
          res_d = pend_res_q;
        end else begin
          res_d              = '0;
          res_d.status       = ST_NONE_DUE;
          res_d.last         = 1'b1;
          res_d.active_count = 4'(count_q);
        end
        res_valid_d = 1'b1;
        pend_d      = 1'b0;
        state_d     = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      snap_q      <= 1'b0;
      idx_q       <= '0;
      used_q      <= '0;
      count_q     <= '0;
      stopped_q   <= 1'b0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      snap_q      <= snap_d;
      idx_q       <= idx_d;
      used_q      <= used_d;
      count_q     <= count_d;
      stopped_q   <= stopped_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q     <= item_d;
    pend_res_q <= pend_res_d;
    ent_q      <= ent_d;
    res_q      <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

`ifndef SYNTHESIS
  // The running count of used slots always matches the used flags.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count_q) == 32'($countones(used_q)))
    else $error("active count does not match used flags");

  // A stopped table holds no slots.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    stopped_q |-> (used_q == '0))
    else $error("stopped table still holds slots");

  // Every command transfer either starts work or answers at once.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> (busy || result_valid_o))
    else $error("command transfer produced neither work nor result");

  // A result that is not the final one always has more work behind it.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && !result_o.last) |-> busy)
    else $error("non-final result while idle");
`endif

endmodule

@@ tb/sv/periodic_task_slot_table_tb.sv @@
// Self-checking testbench for periodic_task_slot_table: directed and random
// commands, an in-order slot table predictor and a result checker.
// Depends on ptst_pkg and the RTL of the block; reads and writes no files.
module periodic_task_slot_table_tb import ptst_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SLOTS = SLOTS_DEF;

  // Operation codes 5 to 7 are reserved; the block must answer them with a
  // refusal and leave the table alone.
  localparam logic [2:0] OP_RESERVED_MIN = 3'd5;
  localparam logic [2:0] OP_RESERVED_MAX = 3'd7;

  // Cycles without any transfer in either direction before the run is
  // declared hung. The slowest legal command is a run-ready that fires all
  // eight slots, and sender gaps are short.
  localparam int IDLE_LIMIT = 2000;
  // Quiet cycles after the last expected result, to catch stray results.
  localparam int TAIL_CYCLES = 40;
  localparam int RANDOM_ITEMS = 195;

  // A queued command, plus a flag that makes the sender hold it back until
  // every result already expected has come out of the block.
  typedef struct packed {
    ptst_in_t cmd;
    logic     wait_idle;
  } backlog_entry_t;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  ptst_in_t  item_i = '0;
  logic      result_valid_o;
  ptst_out_t result_o;

  backlog_entry_t cmd_backlog[$];
  ptst_out_t      pending_results[$];
  int             total_items = 0;
  int             accepted_items = 0;
  int             checked_results = 0;
  int             mismatch_count = 0;
  int             idle_cycles = 0;
  int             burst_left = 1;
  int             gap_left = 0;

  // Shadow copy of the slot table, updated at every command transfer.
  logic        tab_used     [SLOTS];
  logic        tab_entry    [SLOTS];
  logic [31:0] tab_period   [SLOTS];
  logic [63:0] tab_due      [SLOTS];
  logic [63:0] tab_last_run [SLOTS];
  logic [31:0] tab_runs     [SLOTS];
  logic        tab_stopped = 1'b0;

  periodic_task_slot_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .item_i        (item_i),
    .result_valid_o(result_valid_o),
    .result_o      (result_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  task automatic clear_table();
    for (int i = 0; i < SLOTS; i++) begin
      tab_used[i]     = 1'b0;
      tab_entry[i]    = 1'b0;
      tab_period[i]   = '0;
      tab_due[i]      = '0;
      tab_last_run[i] = '0;
      tab_runs[i]     = '0;
    end
  endtask

  function automatic int used_total();
    int n;
    n = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (tab_used[i]) n++;
    end
    return n;
  endfunction

  // Builds one result from the table as it stands after the command. Slot
  // contents are only filled in for fired slots and snapshots; every other
  // result carries zeros there.
  function automatic ptst_out_t slot_result(logic [1:0] status, int idx, bit with_slot);
    ptst_out_t r;
    r = '0;
    r.status       = status;
    r.last         = 1'b1;
    r.active_count = 4'(used_total());
    if (with_slot) begin
      r.slot           = 3'(idx);
      r.slot_used      = tab_used[idx];
      r.slot_has_entry = tab_entry[idx];
      r.slot_period    = tab_period[idx];
      r.slot_next_due  = tab_due[idx];
      r.slot_last_run  = tab_last_run[idx];
      r.slot_run_count = tab_runs[idx];
    end
    return r;
  endfunction

  // Applies one accepted command to the shadow table and queues the
  // results the block must produce for it, in order.
  task automatic predict_results(input ptst_in_t cmd);
    ptst_out_t   held;
    bit          have_held;
    int          free_idx;
    logic [31:0] per;
    have_held = 1'b0;
    free_idx  = -1;
    case (cmd.operation)
      OP_CLEAR: begin
        clear_table();
        tab_stopped = 1'b0;
        pending_results.push_back(slot_result(ST_OK, 0, 1'b0));
      end
      OP_CREATE: begin
        if (!tab_stopped) begin
          for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!tab_used[i]) free_idx = i;
          end
        end
        if (free_idx < 0) begin
          // Stopped, or every slot taken.
          pending_results.push_back(slot_result(ST_REFUSED, 0, 1'b0));
        end else begin
          // A zero period would make the task due forever; it becomes one.
          per = (cmd.period == '0) ? 32'd1 : cmd.period;
          tab_used[free_idx]     = 1'b1;
          tab_entry[free_idx]    = cmd.has_entry;
          tab_period[free_idx]   = per;
          tab_due[free_idx]      = cmd.first_due_now ? cmd.now : cmd.now + 64'(per);
          tab_last_run[free_idx] = '0;
          tab_runs[free_idx]     = '0;
          held      = slot_result(ST_OK, 0, 1'b0);
          held.slot = 3'(free_idx);
          pending_results.push_back(held);
        end
      end
      OP_RUN: begin
        if (tab_stopped) begin
          pending_results.push_back(slot_result(ST_REFUSED, 0, 1'b0));
        end else begin
          // Scan in ascending slot order; each fired slot gets its own result
          // and only the final one carries the last flag.
          for (int i = 0; i < SLOTS; i++) begin
            if (tab_used[i] && tab_entry[i] && cmd.now >= tab_due[i]) begin
              tab_last_run[i] = cmd.now;
              tab_runs[i]     = tab_runs[i] + 32'd1;
              tab_due[i]      = cmd.now + 64'(tab_period[i]);
              if (have_held) begin
                held.last = 1'b0;
                pending_results.push_back(held);
              end
              held      = slot_result(ST_OK, i, 1'b1);
              have_held = 1'b1;
            end
          end
          if (have_held) pending_results.push_back(held);
          else pending_results.push_back(slot_result(ST_NONE_DUE, 0, 1'b0));
        end
      end
      OP_SHUTDOWN: begin
        tab_stopped = 1'b1;
        clear_table();
        pending_results.push_back(slot_result(ST_OK, 0, 1'b0));
      end
      OP_SNAPSHOT: begin
        if (cmd.slot_index >= SLOTS) begin
          pending_results.push_back(slot_result(ST_BAD_INDEX, 0, 1'b0));
        end else begin
          pending_results.push_back(slot_result(ST_OK, int'(cmd.slot_index), 1'b1));
        end
      end
      default: begin
        pending_results.push_back(slot_result(ST_REFUSED, 0, 1'b0));
      end
    endcase
  endtask

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  task automatic queue_cmd(input logic [2:0] op, input logic [63:0] tick,
                           input logic [31:0] per, input logic run_now,
                           input logic entry, input logic [3:0] idx,
                           input logic drain);
    backlog_entry_t e;
    e.cmd.operation     = op;
    e.cmd.now           = tick;
    e.cmd.period        = per;
    e.cmd.first_due_now = run_now;
    e.cmd.has_entry     = entry;
    e.cmd.slot_index    = idx;
    e.wait_idle         = drain;
    cmd_backlog.push_back(e);
  endtask

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("periodic_task_slot_table_tb: mismatch at %0t: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got,
                             input logic [63:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("result %0d field %s is %h, expected %h",
                                checked_results, name, got, want));
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver
  // ---------------------------------------------------------------------
  // A command transfer happens at an edge where start is high and busy is
  // low. The driver predicts the results at that edge, then decides what to
  // present next. Start and item_i each get exactly one nonblocking
  // assignment per edge, so a command that follows directly on the one just
  // taken keeps start high without a glitch. The sender works in bursts;
  // between bursts it idles for a random number of cycles, and those gaps
  // land on whatever phase the block happens to be in.
  always @(posedge clk_i) begin : driver
    backlog_entry_t nxt;
    logic           take;
    logic           drive_start;
    ptst_in_t       drive_item;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      take        = start && !busy;
      drive_start = start && !take;
      drive_item  = item_i;
      if (take) begin
        predict_results(item_i);
        accepted_items++;
      end
      if (!drive_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_backlog.size() != 0 &&
                     !(cmd_backlog[0].wait_idle && pending_results.size() != 0)) begin
          nxt         = cmd_backlog.pop_front();
          drive_start = 1'b1;
          drive_item  = nxt.cmd;
          burst_left--;
          if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            // One burst in four runs straight on without a gap.
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
      end
      start  <= drive_start;
      item_i <= drive_item;
    end
  end

  // ---------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------
  // Every strobed result is taken at the edge ending its cycle and compared
  // field by field with the oldest expectation.
  always @(posedge clk_i) begin : monitor
    ptst_out_t want;
    if (rst_ni && result_valid_o) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("result with nothing expected, status %0d slot %0d",
                                  result_o.status, result_o.slot));
      end else begin
        want = pending_results.pop_front();
        check_field("status",         64'(result_o.status),         64'(want.status));
        check_field("slot",           64'(result_o.slot),           64'(want.slot));
        check_field("last",           64'(result_o.last),           64'(want.last));
        check_field("active_count",   64'(result_o.active_count),   64'(want.active_count));
        check_field("slot_used",      64'(result_o.slot_used),      64'(want.slot_used));
        check_field("slot_has_entry", 64'(result_o.slot_has_entry), 64'(want.slot_has_entry));
        check_field("slot_period",    64'(result_o.slot_period),    64'(want.slot_period));
        check_field("slot_next_due",  result_o.slot_next_due,       want.slot_next_due);
        check_field("slot_last_run",  result_o.slot_last_run,       want.slot_last_run);
        check_field("slot_run_count", 64'(result_o.slot_run_count), 64'(want.slot_run_count));
      end
      checked_results++;
    end
  end

  // Watchdog: any transfer, in either direction, resets the idle count.
  always @(posedge clk_i) begin : watchdog
    if (rst_ni) begin
      if ((start && !busy) || result_valid_o) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("periodic_task_slot_table_tb: no transfer for %0d cycles", IDLE_LIMIT);
        $display("periodic_task_slot_table_tb: FAIL");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------
  initial begin : stimulus
    logic [63:0] tick_base;
    logic [63:0] tick;
    logic [31:0] per;
    logic [3:0]  idx;
    logic [2:0]  op;
    int          pick;
    clear_table();

    // Directed part. It starts from the reset table, works both time
    // extremes so that due times wrap, and walks through the stopped state.
    queue_cmd(OP_SNAPSHOT, '0, '0, 1'b0, 1'b0, 4'd0, 1'b0);
    queue_cmd(OP_RUN, '0, '0, 1'b0, 1'b0, 4'd0, 1'b0);              // nothing due
    queue_cmd(OP_CREATE, '0, '0, 1'b1, 1'b1, 4'd0, 1'b0);           // zero period
    queue_cmd(OP_CREATE, '1, '1, 1'b0, 1'b1, 4'd0, 1'b0);           // due wraps
    queue_cmd(OP_CREATE, 64'd5, 32'd3, 1'b1, 1'b0, 4'd0, 1'b0);     // never fires
    queue_cmd(OP_RUN, '0, '0, 1'b0, 1'b0, 4'd0, 1'b0);
    queue_cmd(OP_RUN, '1, '0, 1'b0, 1'b0, 4'd0, 1'b0);              // two fire, wrap
    queue_cmd(OP_SNAPSHOT, '0, '0, 1'b0, 1'b0, 4'd1, 1'b0);
    queue_cmd(OP_SNAPSHOT, '0, '0, 1'b0, 1'b0, 4'd2, 1'b0);
    queue_cmd(OP_SNAPSHOT, '0, '0, 1'b0, 1'b0, 4'd8, 1'b0);         // bad index
    queue_cmd(OP_SNAPSHOT, '0, '0, 1'b0, 1'b0, 4'd15, 1'b0);
    for (int i = 0; i < 5; i++) begin
      queue_cmd(OP_CREATE, 64'd10, 32'(i), 1'(i), 1'b1, 4'd0, 1'b0);
    end
    queue_cmd(OP_CREATE, 64'd10, 32'd1, 1'b1, 1'b1, 4'd0, 1'b0);    // table full
    queue_cmd(OP_RUN, 64'd12, '0, 1'b0, 1'b0, 4'd0, 1'b0);          // many fire
    queue_cmd(OP_RESERVED_MIN, '1, '1, 1'b1, 1'b1, 4'd7, 1'b0);
    queue_cmd(OP_RESERVED_MAX, '0, '0, 1'b0, 1'b0, 4'd0, 1'b0);
    // Hold back until the block has gone quiet, then stop it.
    queue_cmd(OP_SHUTDOWN, '0, '0, 1'b0, 1'b0, 4'd0, 1'b1);
    queue_cmd(OP_CREATE, 64'd20, 32'd2, 1'b1, 1'b1, 4'd0, 1'b0);    // refused
    queue_cmd(OP_RUN, 64'd20, '0, 1'b0, 1'b0, 4'd0, 1'b0);          // refused
    queue_cmd(OP_SNAPSHOT, '0, '0, 1'b0, 1'b0, 4'd7, 1'b0);
    queue_cmd(OP_CLEAR, '0, '0, 1'b0, 1'b0, 4'd0, 1'b0);
    queue_cmd(OP_CREATE, 64'd30, 32'd4, 1'b1, 1'b1, 4'd0, 1'b0);

    // Random part. Time mostly moves forward in small steps with short
    // periods, so slots keep falling due and firing in mixed groups. Now and
    // then time jumps to a random point or close to the wrap, periods take
    // full-width values, and the sender waits for the block to drain.
    tick_base = 64'd40;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      tick_base = tick_base + 64'($urandom_range(0, 6));
      tick = tick_base;
      if ($urandom_range(0, 19) == 0) tick = {$urandom(), $urandom()};
      pick = $urandom_range(0, 9);
      if (pick == 0) per = $urandom();
      else if (pick == 1) per = '1;
      else per = 32'($urandom_range(0, 12));
      idx = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 7));
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        op = OP_CREATE;
      end else if (pick < 68) begin
        op = OP_RUN;
      end else if (pick < 86) begin
        op = OP_SNAPSHOT;
      end else if (pick < 94) begin
        op = OP_CLEAR;
        // Relocate the time base: sometimes just short of the wrap.
        pick = $urandom_range(0, 3);
        if (pick == 0) tick_base = 64'hFFFF_FFFF_FFFF_FF80 + 64'($urandom_range(0, 63));
        else if (pick == 1) tick_base = {$urandom(), $urandom()};
      end else if (pick < 97) begin
        op = OP_SHUTDOWN;
      end else begin
        op = 3'($urandom_range(OP_RESERVED_MIN, OP_RESERVED_MAX));
      end
      queue_cmd(op, tick, per, 1'($urandom_range(0, 1)),
                1'($urandom_range(0, 6) != 0), idx, 1'($urandom_range(0, 24) == 0));
    end
    total_items = cmd_backlog.size();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Wait until every command has been taken and every result checked.
    do begin
      @(posedge clk_i);
    end while (accepted_items != total_items || pending_results.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("periodic_task_slot_table_tb: PASS");
    end else begin
      $display("periodic_task_slot_table_tb: FAIL");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/ptst_pkg.sv
sv/ptst_ram.sv
sv/ptst_alu.sv
sv/periodic_task_slot_table.sv
tb/sv/periodic_task_slot_table_tb.sv
